// ===== src/smzd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smzd_pkg
// shared widths, datapath opcodes and the controller command word
// ---------------------------------------------------------------------------
package smzd_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int DIST_W      = 32;
    localparam int CFG_W       = 7;
    localparam int MAX_LEN_DEF = 64;
    localparam int SQRT_W      = 64;
    localparam int SQRT_STEPS  = 32;
    localparam int FRAC_W      = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd2;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_CLR,
        OP_SUM,
        OP_MEAN_LD,
        OP_MEAN_SET,
        OP_VAR_LD,
        OP_Z_LD,
        OP_DIV,
        OP_SQRT_LD_VAR,
        OP_SQRT_LD_DIST,
        OP_SQRT,
        OP_DEN_SET,
        OP_DIFF_SRC,
        OP_DIFF_Z,
        OP_MUL,
        OP_ACC_VAR,
        OP_ACC_DIST,
        OP_Z_SET,
        OP_MIN,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   src_ring;
        logic   sh_we;
        logic   sh_wsel_z;
        logic   ring_we;
    } dp_cmd_t;

endpackage

// ===== src/smzd_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smzd channel interfaces
// sample input, result output and length configuration channels
// ---------------------------------------------------------------------------
interface smzd_item_if
    import smzd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                op;
    logic [SAMPLE_W-1:0] sample;
    logic                last;

    modport source (output valid, output op, output sample, output last, input ready);
    modport sink   (input valid, input op, input sample, input last, output ready);
endinterface

interface smzd_result_if
    import smzd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] min_distance;
    logic              too_short;

    modport source (output valid, output min_distance, output too_short, input ready);
    modport sink   (input valid, input min_distance, input too_short, output ready);
endinterface

interface smzd_cfg_if
    import smzd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/smzd_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smzd_ram
// simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module smzd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/smzd_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smzd_datapath
// sample stores, shared bit-serial divider, shared square root, multiplier
// ---------------------------------------------------------------------------
module smzd_datapath
    import smzd_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dp_cmd_t                      cmd,
    input  logic [$clog2(MAX_LEN+1)-1:0] len,
    input  logic [SAMPLE_W-1:0]          sample,
    input  logic [$clog2(MAX_LEN)-1:0]   sh_waddr,
    input  logic [$clog2(MAX_LEN)-1:0]   sh_raddr,
    input  logic [$clog2(MAX_LEN)-1:0]   ring_waddr,
    input  logic [$clog2(MAX_LEN)-1:0]   ring_raddr,
    output logic [DIST_W-1:0]            min_distance,
    output logic                         too_short
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int SUM_W = SAMPLE_W + LEN_W;
    localparam int ACC_W = SQRT_W + LEN_W;
    localparam int DVS_W = SAMPLE_W + 1;
    localparam int PRD_W = 2 * SAMPLE_W + 1;

    logic [SAMPLE_W-1:0] sh_rd;
    logic [SAMPLE_W-1:0] ring_rd;
    logic [SAMPLE_W-1:0] src_rd;
    logic [SAMPLE_W-1:0] sh_wdata;

    logic signed [SUM_W-1:0] sum_reg;
    logic [SAMPLE_W-1:0]     mean_reg;
    logic [DVS_W-1:0]        m_reg;
    logic                    neg_reg;
    logic [PRD_W-1:0]        prod_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [DVS_W-1:0]        rem_reg;
    logic [DVS_W-1:0]        dvs_reg;
    logic [ACC_W-1:0]        quo_reg;
    logic [SQRT_W-1:0]       v_reg;
    logic [SQRT_W-1:0]       r_reg;
    logic [SQRT_W-1:0]       bit_reg;
    logic [DVS_W-1:0]        den_reg;
    logic [SAMPLE_W-1:0]     z_reg;
    logic [DIST_W-1:0]       min_reg;
    logic                    seen_reg;
    logic [DIST_W-1:0]       res_min_reg;
    logic                    res_short_reg;

    logic [DVS_W:0]          div_try;
    logic                    div_ge;
    logic [DVS_W:0]          diff_a;
    logic [DVS_W:0]          diff_b;
    logic [DVS_W:0]          diff;
    logic [SUM_W-1:0]        sum_mag;
    logic [SQRT_W-1:0]       sq_t;
    logic [PRD_W:0]          acc_sat;
    logic [DIST_W-1:0]       dist_val;
    logic [PRD_W-1:0]        mul_full;

    smzd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LEN)) u_sh_ram (
        .clk   (clk),
        .we    (cmd.sh_we),
        .waddr (sh_waddr),
        .wdata (sh_wdata),
        .raddr (sh_raddr),
        .rdata (sh_rd)
    );

    smzd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LEN)) u_ring_ram (
        .clk   (clk),
        .we    (cmd.ring_we),
        .waddr (ring_waddr),
        .wdata (sample),
        .raddr (ring_raddr),
        .rdata (ring_rd)
    );

    always_comb
    begin
        sh_wdata = cmd.sh_wsel_z ? z_reg : sample;
        src_rd   = cmd.src_ring ? ring_rd : sh_rd;
        div_try  = {rem_reg, quo_reg[ACC_W-1]};
        div_ge   = div_try >= {1'b0, dvs_reg};
        if (cmd.op == OP_DIFF_Z)
        begin
            diff_a = {{2{z_reg[SAMPLE_W-1]}}, z_reg};
            diff_b = {{2{sh_rd[SAMPLE_W-1]}}, sh_rd};
        end
        else
        begin
            diff_a = {{2{src_rd[SAMPLE_W-1]}}, src_rd};
            diff_b = {{2{mean_reg[SAMPLE_W-1]}}, mean_reg};
        end
        diff     = diff_a - diff_b;
        sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        sq_t     = r_reg + bit_reg;
        acc_sat  = {1'b0, PRD_W'(acc_reg[SQRT_W-1:0])} + {1'b0, prod_reg};
        dist_val = r_reg[DIST_W-1:0];
        mul_full = PRD_W'(m_reg * m_reg);
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_CLR:
            begin
                sum_reg <= '0;
                acc_reg <= '0;
            end
            OP_SUM:
                sum_reg <= sum_reg + SUM_W'(signed'(src_rd));
            OP_MEAN_LD:
            begin
                neg_reg <= sum_reg[SUM_W-1];
                quo_reg <= ACC_W'(sum_mag);
                rem_reg <= '0;
                dvs_reg <= DVS_W'(len);
            end
            OP_MEAN_SET:
                mean_reg <= neg_reg ? -quo_reg[SAMPLE_W-1:0] : quo_reg[SAMPLE_W-1:0];
            OP_VAR_LD:
            begin
                quo_reg <= acc_reg;
                rem_reg <= '0;
                dvs_reg <= DVS_W'(len) - DVS_W'(1);
            end
            OP_Z_LD:
            begin
                quo_reg <= ACC_W'({m_reg, {FRAC_W{1'b0}}});
                rem_reg <= '0;
                dvs_reg <= den_reg;
            end
            OP_DIV:
            begin
                rem_reg <= div_ge ? DVS_W'(div_try - {1'b0, dvs_reg})
                                  : div_try[DVS_W-1:0];
                quo_reg <= {quo_reg[ACC_W-2:0], div_ge};
            end
            OP_SQRT_LD_VAR:
            begin
                v_reg   <= (|quo_reg[ACC_W-1:SQRT_W]) ? '1 : quo_reg[SQRT_W-1:0];
                r_reg   <= '0;
                bit_reg <= SQRT_W'(1) << (SQRT_W - 2);
            end
            OP_SQRT_LD_DIST:
            begin
                v_reg   <= acc_reg[SQRT_W-1:0];
                r_reg   <= '0;
                bit_reg <= SQRT_W'(1) << (SQRT_W - 2);
            end
            OP_SQRT:
            begin
                if (v_reg >= sq_t)
                begin
                    v_reg <= v_reg - sq_t;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_DEN_SET:
            begin
                den_reg <= {1'b0, r_reg[SAMPLE_W-1:0]} + DVS_W'(1);
                acc_reg <= '0;
            end
            OP_DIFF_SRC, OP_DIFF_Z:
            begin
                neg_reg <= diff[DVS_W];
                m_reg   <= diff[DVS_W] ? DVS_W'(-diff) : diff[DVS_W-1:0];
            end
            OP_MUL:
                prod_reg <= mul_full;
            OP_ACC_VAR:
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            OP_ACC_DIST:
                acc_reg <= (|acc_sat[PRD_W:SQRT_W]) ? ACC_W'({SQRT_W{1'b1}})
                                                    : ACC_W'(acc_sat[SQRT_W-1:0]);
            OP_Z_SET:
            begin
                if (neg_reg)
                begin
                    z_reg <= (quo_reg >= ACC_W'(33'h080000000)) ? 32'h80000000
                                                               : -quo_reg[SAMPLE_W-1:0];
                end
                else
                begin
                    z_reg <= (quo_reg > ACC_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF
                                                             : quo_reg[SAMPLE_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= '0;
            seen_reg      <= 1'b0;
            res_min_reg   <= '0;
            res_short_reg <= 1'b0;
        end
        else if (cmd.op == OP_MIN)
        begin
            if (!seen_reg || dist_val < min_reg)
            begin
                min_reg <= dist_val;
            end
            seen_reg <= 1'b1;
        end
        else if (cmd.op == OP_RESULT)
        begin
            res_min_reg   <= seen_reg ? min_reg : '0;
            res_short_reg <= !seen_reg;
            min_reg       <= '0;
            seen_reg      <= 1'b0;
        end
    end

    assign min_distance = res_min_reg;
    assign too_short    = res_short_reg;

endmodule

// ===== src/smzd_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smzd_ctrl
// sequencer for load, z-normalization, distance and result handshake
// ---------------------------------------------------------------------------
module smzd_ctrl
    import smzd_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [$clog2(MAX_LEN+1)-1:0] len,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic                         item_op,
    input  logic                         item_last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output dp_cmd_t                      cmd,
    output logic [$clog2(MAX_LEN)-1:0]   sh_waddr,
    output logic [$clog2(MAX_LEN)-1:0]   sh_raddr,
    output logic [$clog2(MAX_LEN)-1:0]   ring_waddr,
    output logic [$clog2(MAX_LEN)-1:0]   ring_raddr
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int AW    = $clog2(MAX_LEN);
    localparam int ACC_W = SQRT_W + LEN_W;
    localparam int CNT_W = $clog2(ACC_W + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_SUM_RD, ST_SUM_ADD, ST_MEAN_LD, ST_MEAN_DIV, ST_MEAN_SET,
        ST_VAR_RD, ST_VAR_DIFF, ST_VAR_MUL, ST_VAR_ACC, ST_VAR_LD, ST_VAR_DIV,
        ST_VAR_SQ_LD, ST_VAR_SQ, ST_DEN, ST_Z_RD, ST_Z_DIFF, ST_Z_LD, ST_Z_DIV,
        ST_Z_SET, ST_Z_WR, ST_D_DIFF, ST_D_MUL, ST_D_ACC, ST_D_SQ_LD, ST_D_SQ,
        ST_MIN, ST_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0] sfill_reg, sfill_next;
    logic [LEN_W-1:0] wfill_reg, wfill_next;
    logic [AW-1:0]    wp_reg, wp_next;
    logic [AW-1:0]    rp_reg, rp_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ring_job_reg, ring_job_next;
    logic             last_pend_reg, last_pend_next;
    logic             out_valid_reg, out_valid_next;

    logic [AW-1:0]    wp_inc;
    logic [AW-1:0]    rp_inc;
    logic [LEN_W-1:0] wfill_inc;
    logic [LEN_W:0]   base_calc;
    logic             elem_last;
    logic             div_done;
    logic             sqrt_done;

    always_comb
    begin
        wp_inc    = (wp_reg == AW'(MAX_LEN - 1)) ? '0 : wp_reg + AW'(1);
        rp_inc    = (rp_reg == AW'(MAX_LEN - 1)) ? '0 : rp_reg + AW'(1);
        wfill_inc = (wfill_reg < LEN_W'(MAX_LEN)) ? wfill_reg + LEN_W'(1) : wfill_reg;
        if ((LEN_W + 1)'(wp_inc) >= (LEN_W + 1)'(len))
        begin
            base_calc = (LEN_W + 1)'(wp_inc) - (LEN_W + 1)'(len);
        end
        else
        begin
            base_calc = (LEN_W + 1)'(wp_inc) + (LEN_W + 1)'(MAX_LEN) - (LEN_W + 1)'(len);
        end
        elem_last = (idx_reg + LEN_W'(1)) == len;
        div_done  = cnt_reg == CNT_W'(ACC_W - 1);
        sqrt_done = cnt_reg == CNT_W'(SQRT_STEPS - 1);
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        sfill_next     = sfill_reg;
        wfill_next     = wfill_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        base_next      = base_reg;
        cnt_next       = cnt_reg;
        ring_job_next  = ring_job_reg;
        last_pend_next = last_pend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '{op: OP_IDLE, src_ring: ring_job_reg, default: 1'b0};
        item_ready     = state_reg == ST_IDLE;
        sh_waddr       = (state_reg == ST_IDLE) ? sfill_reg[AW-1:0] : idx_reg[AW-1:0];
        sh_raddr       = idx_reg[AW-1:0];
        ring_waddr     = wp_reg;
        ring_raddr     = rp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.op = OP_CLR;
                if (item_valid)
                begin
                    idx_next = '0;
                    if (!item_op)
                    begin
                        if (sfill_reg < LEN_W'(MAX_LEN))
                        begin
                            cmd.sh_we  = 1'b1;
                            sfill_next = sfill_reg + LEN_W'(1);
                        end
                        if (item_last)
                        begin
                            sfill_next    = '0;
                            ring_job_next = 1'b0;
                            state_next    = ST_SUM_RD;
                        end
                    end
                    else
                    begin
                        cmd.ring_we    = 1'b1;
                        wp_next        = wp_inc;
                        wfill_next     = wfill_inc;
                        last_pend_next = item_last;
                        if (wfill_inc >= len)
                        begin
                            base_next     = base_calc[AW-1:0];
                            rp_next       = base_calc[AW-1:0];
                            ring_job_next = 1'b1;
                            state_next    = ST_SUM_RD;
                        end
                        else if (item_last)
                        begin
                            state_next = ST_OUT;
                        end
                    end
                end
            end
            ST_SUM_RD:
                state_next = ST_SUM_ADD;
            ST_SUM_ADD:
            begin
                cmd.op = OP_SUM;
                if (elem_last)
                begin
                    idx_next   = '0;
                    rp_next    = base_reg;
                    state_next = ST_MEAN_LD;
                end
                else
                begin
                    idx_next   = idx_reg + LEN_W'(1);
                    rp_next    = rp_inc;
                    state_next = ST_SUM_RD;
                end
            end
            ST_MEAN_LD:
            begin
                cmd.op     = OP_MEAN_LD;
                cnt_next   = '0;
                state_next = ST_MEAN_DIV;
            end
            ST_MEAN_DIV:
            begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg + CNT_W'(1);
                if (div_done)
                begin
                    state_next = ST_MEAN_SET;
                end
            end
            ST_MEAN_SET:
            begin
                cmd.op     = OP_MEAN_SET;
                state_next = ST_VAR_RD;
            end
            ST_VAR_RD:
                state_next = ST_VAR_DIFF;
            ST_VAR_DIFF:
            begin
                cmd.op     = OP_DIFF_SRC;
                state_next = ST_VAR_MUL;
            end
            ST_VAR_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = ST_VAR_ACC;
            end
            ST_VAR_ACC:
            begin
                cmd.op = OP_ACC_VAR;
                if (elem_last)
                begin
                    idx_next   = '0;
                    rp_next    = base_reg;
                    state_next = ST_VAR_LD;
                end
                else
                begin
                    idx_next   = idx_reg + LEN_W'(1);
                    rp_next    = rp_inc;
                    state_next = ST_VAR_RD;
                end
            end
            ST_VAR_LD:
            begin
                cmd.op     = OP_VAR_LD;
                cnt_next   = '0;
                state_next = ST_VAR_DIV;
            end
            ST_VAR_DIV:
            begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg + CNT_W'(1);
                if (div_done)
                begin
                    state_next = ST_VAR_SQ_LD;
                end
            end
            ST_VAR_SQ_LD:
            begin
                cmd.op     = OP_SQRT_LD_VAR;
                cnt_next   = '0;
                state_next = ST_VAR_SQ;
            end
            ST_VAR_SQ:
            begin
                cmd.op   = OP_SQRT;
                cnt_next = cnt_reg + CNT_W'(1);
                if (sqrt_done)
                begin
                    state_next = ST_DEN;
                end
            end
            ST_DEN:
            begin
                cmd.op     = OP_DEN_SET;
                state_next = ST_Z_RD;
            end
            ST_Z_RD:
                state_next = ST_Z_DIFF;
            ST_Z_DIFF:
            begin
                cmd.op     = OP_DIFF_SRC;
                state_next = ST_Z_LD;
            end
            ST_Z_LD:
            begin
                cmd.op     = OP_Z_LD;
                cnt_next   = '0;
                state_next = ST_Z_DIV;
            end
            ST_Z_DIV:
            begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg + CNT_W'(1);
                if (div_done)
                begin
                    state_next = ST_Z_SET;
                end
            end
            ST_Z_SET:
            begin
                cmd.op     = OP_Z_SET;
                state_next = ring_job_reg ? ST_D_DIFF : ST_Z_WR;
            end
            ST_Z_WR:
            begin
                cmd.sh_we     = 1'b1;
                cmd.sh_wsel_z = 1'b1;
                if (elem_last)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + LEN_W'(1);
                    state_next = ST_Z_RD;
                end
            end
            ST_D_DIFF:
            begin
                cmd.op     = OP_DIFF_Z;
                state_next = ST_D_MUL;
            end
            ST_D_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = ST_D_ACC;
            end
            ST_D_ACC:
            begin
                cmd.op = OP_ACC_DIST;
                if (elem_last)
                begin
                    idx_next   = '0;
                    state_next = ST_D_SQ_LD;
                end
                else
                begin
                    idx_next   = idx_reg + LEN_W'(1);
                    rp_next    = rp_inc;
                    state_next = ST_Z_RD;
                end
            end
            ST_D_SQ_LD:
            begin
                cmd.op     = OP_SQRT_LD_DIST;
                cnt_next   = '0;
                state_next = ST_D_SQ;
            end
            ST_D_SQ:
            begin
                cmd.op   = OP_SQRT;
                cnt_next = cnt_reg + CNT_W'(1);
                if (sqrt_done)
                begin
                    state_next = ST_MIN;
                end
            end
            ST_MIN:
            begin
                cmd.op     = OP_MIN;
                state_next = last_pend_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_RESULT;
                    out_valid_next = 1'b1;
                    wfill_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            sfill_reg     <= '0;
            wfill_reg     <= '0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            base_reg      <= '0;
            cnt_reg       <= '0;
            ring_job_reg  <= 1'b0;
            last_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            sfill_reg     <= sfill_next;
            wfill_reg     <= wfill_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            base_reg      <= base_next;
            cnt_reg       <= cnt_next;
            ring_job_reg  <= ring_job_next;
            last_pend_reg <= last_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== src/shapelet_min_znorm_distance_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shapelet_min_znorm_distance_unit
// minimum z-normalized euclidean distance of a series to a stored shapelet
// ---------------------------------------------------------------------------
// One word is taken at a time. A shapelet word that is not last and a series
// word that does not complete a window are written to their store. The last
// shapelet word runs z-normalization over the L stored samples, where the
// shared one-bit-per-cycle divider, with W = 64 + clog2(MAX_LEN + 1) steps,
// dominates (one division for the mean, one for the variance and one per sample).
// A series word that completes a window runs the same steps over the window,
// then the distance and its square root. A result sits in an output register,
// so the next words are taken while it waits; a word that ends a series is also
// taken, but the unit then holds until the waiting result is taken.
module shapelet_min_znorm_distance_unit
    import smzd_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    smzd_item_if.sink     item,
    smzd_result_if.source result,
    smzd_cfg_if.sink      cfg
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int AW    = $clog2(MAX_LEN);

    logic [CFG_W-1:0] len_cfg_reg;
    logic [LEN_W-1:0] len;
    dp_cmd_t          cmd;
    logic [AW-1:0]    sh_waddr;
    logic [AW-1:0]    sh_raddr;
    logic [AW-1:0]    ring_waddr;
    logic [AW-1:0]    ring_raddr;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= CFG_RESET;
        end
        else if (cfg.valid)
        begin
            len_cfg_reg <= cfg.data;
        end
    end

    // clamp length to 2..MAX_LEN
    always_comb
    begin
        if (len_cfg_reg < CFG_W'(2))
        begin
            len = LEN_W'(2);
        end
        else if (32'(len_cfg_reg) > MAX_LEN)
        begin
            len = LEN_W'(MAX_LEN);
        end
        else
        begin
            len = LEN_W'(len_cfg_reg);
        end
    end

    smzd_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .len        (len),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .item_op    (item.op),
        .item_last  (item.last),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .cmd        (cmd),
        .sh_waddr   (sh_waddr),
        .sh_raddr   (sh_raddr),
        .ring_waddr (ring_waddr),
        .ring_raddr (ring_raddr)
    );

    smzd_datapath #(.MAX_LEN(MAX_LEN)) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .len          (len),
        .sample       (item.sample),
        .sh_waddr     (sh_waddr),
        .sh_raddr     (sh_raddr),
        .ring_waddr   (ring_waddr),
        .ring_raddr   (ring_raddr),
        .min_distance (result.min_distance),
        .too_short    (result.too_short)
    );

endmodule
